@@ rtl/lts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the toroidal life generation block.
// No dependencies; imported by every module of the block except lts_ram.
package lts_pkg;

   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   localparam int DIM_W = 7;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
   localparam logic [DIM_W-1:0] DIM_MIN = 7'd3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_COLS = 1'b0;
   localparam logic CSR_ROWS = 1'b1;

   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_STEP  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [2:0] RD_REQ   = 3'd0;
   localparam logic [2:0] RD_LAST  = 3'd1;
   localparam logic [2:0] RD_ROW   = 3'd2;
   localparam logic [2:0] RD_PLUS1 = 3'd3;
   localparam logic [2:0] RD_PLUS2 = 3'd4;

   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_SET  = 2'd1;
   localparam logic [1:0] WR_LIFE = 2'd2;
   localparam logic [1:0] WR_ZERO = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic [2:0] rd_src;
      logic [1:0] wr_src;
      logic       load_prev;
      logic       load_cur;
      logic       load_nxt;
      logic       shift;
      logic       nxt_from_saved;
      logic       row_clr;
      logic       row_inc;
      logic       respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_row;
      logic ahead_wrap;
      logic clear_last;
   } ctrl_status_type;

endpackage

@@ rtl/lts_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lts_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences requests, generation steps and clears.
// Depends on lts_pkg for command and status types.
module lts_ctrl
   import lts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_type,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_REQ_RD   = 4'd1;
   localparam logic [3:0] ST_REQ_DONE = 4'd2;
   localparam logic [3:0] ST_STEP0    = 4'd3;
   localparam logic [3:0] ST_STEP1    = 4'd4;
   localparam logic [3:0] ST_STEP2    = 4'd5;
   localparam logic [3:0] ST_STEP3    = 4'd6;
   localparam logic [3:0] ST_CALC     = 4'd7;
   localparam logic [3:0] ST_ADV      = 4'd8;
   localparam logic [3:0] ST_CLEAR    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       clear_rsp_ff, clear_rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_rsp_ff <= clear_rsp_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      clear_rsp_in = clear_rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_type)
                  REQ_STEP: begin
                     state_in = ST_STEP0;
                  end
                  REQ_CLEAR: begin
                     cmd.row_clr  = 1'b1;
                     clear_rsp_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_REQ_RD;
                  end
               endcase
            end
         end
         ST_REQ_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_REQ;
            state_in   = ST_REQ_DONE;
         end
         ST_REQ_DONE: begin
            cmd.wr_src  = WR_SET;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_STEP0: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_src  = RD_LAST;
            cmd.row_clr = 1'b1;
            state_in    = ST_STEP1;
         end
         ST_STEP1: begin
            cmd.load_prev = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_src    = RD_ROW;
            state_in      = ST_STEP2;
         end
         ST_STEP2: begin
            cmd.load_cur = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_src   = RD_PLUS1;
            state_in     = ST_STEP3;
         end
         ST_STEP3: begin
            cmd.load_nxt = 1'b1;
            state_in     = ST_CALC;
         end
         ST_CALC: begin
            cmd.wr_src = WR_LIFE;
            if (status.last_row) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.shift   = 1'b1;
            cmd.row_inc = 1'b1;
            if (status.ahead_wrap) begin
               cmd.nxt_from_saved = 1'b1;
               state_in           = ST_CALC;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = RD_PLUS2;
               state_in   = ST_STEP3;
            end
         end
         ST_CLEAR: begin
            cmd.wr_src  = WR_ZERO;
            cmd.row_inc = 1'b1;
            if (status.clear_last) begin
               cmd.respond  = clear_rsp_ff;
               clear_rsp_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/lts_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: row buffers, row counter, B3/S23 row evaluation and the grid RAM.
// Depends on lts_pkg and lts_ram.
module lts_datapath
   import lts_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   input  logic [1:0]       req_type,
   input  logic [5:0]       req_cell_col,
   input  logic [5:0]       req_cell_row,
   input  logic             req_new_value,
   input  logic [DIM_W-1:0] cols_in_use,
   input  logic [DIM_W-1:0] rows_in_use,
   output ctrl_status_type  status,
   output logic             rsp_valid,
   output logic             rsp_cell_value,
   output logic [1:0]       rsp_done_kind
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int NC_W  = $clog2(MAX_COLS + 1);
   localparam int NR_W  = $clog2(MAX_ROWS + 1);

   logic [1:0]          kind_ff;
   logic [5:0]          col_ff;
   logic [5:0]          row_sel_ff;
   logic                value_ff;
   logic [MAX_COLS-1:0] prev_ff, cur_ff, nxt_ff, saved_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                rsp_valid_ff;
   logic                rsp_cell_value_ff;
   logic [1:0]          rsp_done_kind_ff;

   logic [NC_W-1:0]     nc;
   logic [NR_W-1:0]     nr;
   logic                in_range;
   logic [COL_W-1:0]    col_idx;
   logic [MAX_COLS-1:0] rd_data;
   logic [MAX_COLS-1:0] wr_data;
   logic [MAX_COLS-1:0] life_row;
   logic                wr_en;
   logic [ROW_W-1:0]    wr_addr;
   logic                rd_en;
   logic [ROW_W-1:0]    rd_addr;

   always_comb begin
      if (cols_in_use < DIM_MIN) begin
         nc = NC_W'(3);
      end else if (int'(cols_in_use) > MAX_COLS) begin
         nc = NC_W'(MAX_COLS);
      end else begin
         nc = NC_W'(cols_in_use);
      end
      if (rows_in_use < DIM_MIN) begin
         nr = NR_W'(3);
      end else if (int'(rows_in_use) > MAX_ROWS) begin
         nr = NR_W'(MAX_ROWS);
      end else begin
         nr = NR_W'(rows_in_use);
      end
   end

   assign in_range = (int'(col_ff) < MAX_COLS) && (int'(row_sel_ff) < MAX_ROWS);
   assign col_idx  = COL_W'(col_ff);

   assign status.last_row   = (int'(row_ff) + 1 == int'(nr));
   assign status.ahead_wrap = (int'(row_ff) + 2 == int'(nr));
   assign status.clear_last = (int'(row_ff) + 1 == MAX_ROWS);

   always_comb begin
      int               lc;
      int               rc;
      logic [3:0]       cnt;
      logic [COL_W-1:0] li;
      logic [COL_W-1:0] ri;
      for (int c = 0; c < MAX_COLS; c++) begin
         lc  = (c == 0) ? int'(nc) - 1 : c - 1;
         rc  = (c + 1 == int'(nc)) ? 0 : (c + 1) % MAX_COLS;
         li  = COL_W'(lc);
         ri  = COL_W'(rc);
         cnt = 4'(prev_ff[li]) + 4'(prev_ff[c]) + 4'(prev_ff[ri])
             + 4'(cur_ff[li]) + 4'(cur_ff[ri])
             + 4'(nxt_ff[li]) + 4'(nxt_ff[c]) + 4'(nxt_ff[ri]);
         if (c < int'(nc)) begin
            life_row[c] = (cnt == 4'd3) || (cur_ff[c] && (cnt == 4'd2));
         end else begin
            life_row[c] = cur_ff[c];
         end
      end
   end

   always_comb begin
      rd_en = cmd.rd_en;
      case (cmd.rd_src)
         RD_REQ: begin
            rd_addr = ROW_W'(row_sel_ff);
            rd_en   = cmd.rd_en && in_range;
         end
         RD_LAST:  rd_addr = ROW_W'(int'(nr) - 1);
         RD_ROW:   rd_addr = row_ff;
         RD_PLUS1: rd_addr = ROW_W'(int'(row_ff) + 1);
         RD_PLUS2: rd_addr = ROW_W'(int'(row_ff) + 2);
         default:  rd_addr = row_ff;
      endcase
   end

   always_comb begin
      wr_data = rd_data;
      wr_addr = row_ff;
      wr_en   = 1'b0;
      case (cmd.wr_src)
         WR_SET: begin
            wr_data[col_idx] = value_ff;
            wr_addr          = ROW_W'(row_sel_ff);
            wr_en            = in_range && (kind_ff == REQ_SET);
         end
         WR_LIFE: begin
            wr_data = life_row;
            wr_en   = 1'b1;
         end
         WR_ZERO: begin
            wr_data = '0;
            wr_en   = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   lts_ram #(
      .WIDTH(MAX_COLS),
      .DEPTH(MAX_ROWS)
   ) u_grid (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_type;
         col_ff     <= req_cell_col;
         row_sel_ff <= req_cell_row;
         value_ff   <= req_new_value;
      end
      if (cmd.load_prev) begin
         prev_ff <= rd_data;
      end
      if (cmd.load_cur) begin
         cur_ff   <= rd_data;
         saved_ff <= rd_data;
      end
      if (cmd.shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt_ff;
      end
      if (cmd.nxt_from_saved) begin
         nxt_ff <= saved_ff;
      end else if (cmd.load_nxt) begin
         nxt_ff <= rd_data;
      end
      rsp_cell_value_ff <= (kind_ff == REQ_READ) && in_range && rd_data[col_idx];
      rsp_done_kind_ff  <= kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.row_clr) begin
            row_ff <= '0;
         end else if (cmd.row_inc) begin
            row_ff <= ROW_W'(int'(row_ff) + 1);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_done_kind  = rsp_done_kind_ff;

endmodule

@@ rtl/life_torus_generation_step.sv @@
`timescale 1ns / 1ps
// Set and read requests read the RAM row, then update it (set) and send a registered result.
// A step reads and rewrites the grid one row per pass.
// A clear writes one RAM row per cycle, through all MAX_ROWS rows.
// One request at a time; busy is high while a request is in progress.
// After reset the grid is cleared with busy high and no result.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module life_torus_generation_step
   import lts_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [5:0]            req_cell_col,
   input  logic [5:0]            req_cell_row,
   input  logic                  req_new_value,
   output logic                  rsp_valid,
   output logic                  rsp_cell_value,
   output logic [1:0]            rsp_done_kind,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [DIM_W-1:0] cols_ff, rows_ff;
   logic             csr_write;
   ctrl_cmd_type     cmd;
   ctrl_status_type  status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_write) begin
         if (paddr[2] == CSR_COLS) begin
            cols_ff <= pwdata[DIM_W-1:0];
         end else begin
            rows_ff <= pwdata[DIM_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == CSR_ROWS) begin
         prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, rows_ff};
      end else begin
         prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, cols_ff};
      end
   end

   lts_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_type(req_type),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   lts_datapath #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_type),
      .req_cell_col  (req_cell_col),
      .req_cell_row  (req_cell_row),
      .req_new_value (req_new_value),
      .cols_in_use   (cols_ff),
      .rows_in_use   (rows_ff),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_cell_value(rsp_cell_value),
      .rsp_done_kind (rsp_done_kind)
   );

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while a request is still in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_done_kind != REQ_READ)) |-> !rsp_cell_value)
      else $error("nonzero cell value on a result that is not a read");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

endmodule

@@ tb/life_torus_generation_step_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the toroidal life generation block: watches the request, result
// and register ports, predicts every result and counts mismatches.
// Depends on lts_pkg for the request codes, register addresses and widths.
module life_torus_generation_step_checker
   import lts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [5:0]            req_cell_col,
   input  logic [5:0]            req_cell_row,
   input  logic                  req_new_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_cell_value,
   input  logic [1:0]            rsp_done_kind,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    pending_count,
   output int                    fail_count
);

   typedef struct packed {
      logic       cell_value;
      logic [1:0] done_kind;
   } life_result_type;

   logic [DEF_MAX_COLS-1:0] cell_grid [DEF_MAX_ROWS];
   logic [DIM_W-1:0]        cols_reg;
   logic [DIM_W-1:0]        rows_reg;
   life_result_type         result_q [$];
   int                      failures = 0;

   function automatic int used_span(input logic [DIM_W-1:0] value, input int limit);
      if (value < DIM_MIN) return int'(DIM_MIN);
      if (int'(value) > limit) return limit;
      return int'(value);
   endfunction

   // Every new cell is computed from the old generation; cells outside the
   // area in use keep their value.
   function automatic void advance_generation();
      logic [DEF_MAX_COLS-1:0] old_grid [DEF_MAX_ROWS];
      int                      nc;
      int                      nr;
      int                      n;
      int                      cc;
      int                      rr;
      old_grid = cell_grid;
      nc = used_span(cols_reg, DEF_MAX_COLS);
      nr = used_span(rows_reg, DEF_MAX_ROWS);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            n = 0;
            for (int dr = 0; dr < 3; dr++) begin
               for (int dc = 0; dc < 3; dc++) begin
                  if (!(dr == 1 && dc == 1)) begin
                     cc = (c + nc + dc - 1) % nc;
                     rr = (r + nr + dr - 1) % nr;
                     n += old_grid[rr][cc];
                  end
               end
            end
            cell_grid[r][c] = old_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      life_result_type  expected_result;
      logic [DIM_W-1:0] expected_reg;
      if (reset) begin
         for (int r = 0; r < DEF_MAX_ROWS; r++) cell_grid[r] = '0;
         cols_reg = DIM_RESET;
         rows_reg = DIM_RESET;
         result_q.delete();
      end else begin
         if (rsp_valid) begin
            if (result_q.size() == 0) begin
               $error("unexpected result transfer: cell_value %0d done_kind %0d",
                      rsp_cell_value, rsp_done_kind);
               failures++;
            end else begin
               expected_result = result_q.pop_front();
               if (rsp_cell_value !== expected_result.cell_value) begin
                  $error("cell_value: expected %0d, actual %0d",
                         expected_result.cell_value, rsp_cell_value);
                  failures++;
               end
               if (rsp_done_kind !== expected_result.done_kind) begin
                  $error("done_kind: expected %0d, actual %0d",
                         expected_result.done_kind, rsp_done_kind);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            expected_result.done_kind = req_type;
            expected_result.cell_value = 1'b0;
            case (req_type)
               REQ_SET: begin
                  cell_grid[req_cell_row][req_cell_col] = req_new_value;
               end
               REQ_READ: begin
                  expected_result.cell_value = cell_grid[req_cell_row][req_cell_col];
               end
               REQ_STEP: begin
                  advance_generation();
               end
               default: begin
                  for (int r = 0; r < DEF_MAX_ROWS; r++) cell_grid[r] = '0;
               end
            endcase
            result_q.push_back(expected_result);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == {CSR_COLS, 2'b00}) cols_reg = pwdata[DIM_W-1:0];
               else if (paddr == {CSR_ROWS, 2'b00}) rows_reg = pwdata[DIM_W-1:0];
            end else begin
               expected_reg = (paddr == {CSR_ROWS, 2'b00}) ? rows_reg : cols_reg;
               if (prdata !== {{(CSR_DATA_W - DIM_W){1'b0}}, expected_reg}) begin
                  $error("prdata: expected %0d, actual %0d", expected_reg, prdata);
                  failures++;
               end
            end
         end
      end
      pending_count <= result_q.size();
      fail_count <= failures;
   end

endmodule

@@ tb/life_torus_generation_step_test.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the toroidal life generation block: drives requests
// and register transfers, and gives the verdict from the checker's failure count.
// Depends on lts_pkg, life_torus_generation_step and its checker module.
module life_torus_generation_step_test;
   import lts_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = REQ_SET;
   logic [5:0]            req_cell_col = '0;
   logic [5:0]            req_cell_row = '0;
   logic                  req_new_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_cell_value;
   logic [1:0]            rsp_done_kind;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    pending_count;
   int                    fail_count;
   int                    cycle_count = 0;
   int                    quiet_left = 0;

   life_torus_generation_step uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .req_new_value(req_new_value), .rsp_valid(rsp_valid),
      .rsp_cell_value(rsp_cell_value), .rsp_done_kind(rsp_done_kind),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   life_torus_generation_step_checker life_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .req_new_value(req_new_value), .rsp_valid(rsp_valid),
      .rsp_cell_value(rsp_cell_value), .rsp_done_kind(rsp_done_kind),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .pending_count(pending_count), .fail_count(fail_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic issue_request(input logic [1:0] kind, input logic [5:0] col,
                                input logic [5:0] row, input logic value);
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(4, 12);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 8);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_cell_col <= col;
      req_cell_row <= row;
      req_new_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic idx, input logic write,
                             input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_cols [8];
      logic [CSR_DATA_W-1:0] phase_rows [8];
      int                    area_cols;
      int                    area_rows;
      int                    pick;
      logic [1:0]            kind;
      logic [5:0]            col;
      logic [5:0]            row;

      phase_cols = '{32'd3, 32'd0, 32'd127, 32'hFFFF_FF85, 32'd64, 32'd6, 32'd0, 32'd0};
      phase_rows = '{32'd3, 32'd1, 32'd2, 32'd9, 32'd3, 32'd64, 32'd0, 32'd0};
      phase_cols[6] = $urandom_range(3, 12);
      phase_rows[6] = $urandom_range(3, 12);
      phase_cols[7] = $urandom_range(0, 127);
      phase_rows[7] = $urandom_range(0, 127);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(CSR_COLS, 1'b0, '0);
      csr_access(CSR_ROWS, 1'b0, '0);

      // A blinker that straddles both wrap borders of the full grid.
      issue_request(REQ_READ, 6'd0, 6'd0, 1'b0);
      issue_request(REQ_READ, 6'd63, 6'd63, 1'b1);
      issue_request(REQ_SET, 6'd62, 6'd63, 1'b1);
      issue_request(REQ_SET, 6'd63, 6'd63, 1'b1);
      issue_request(REQ_SET, 6'd0, 6'd63, 1'b1);
      issue_request(REQ_SET, 6'd5, 6'd5, 1'b0);
      issue_request(REQ_READ, 6'd63, 6'd63, 1'b0);
      issue_request(REQ_STEP, 6'd0, 6'd0, 1'b0);
      issue_request(REQ_READ, 6'd63, 6'd0, 1'b0);
      issue_request(REQ_READ, 6'd62, 6'd63, 1'b0);
      issue_request(REQ_STEP, 6'd63, 6'd63, 1'b1);
      issue_request(REQ_READ, 6'd0, 6'd63, 1'b0);
      issue_request(REQ_CLEAR, 6'd63, 6'd63, 1'b1);
      issue_request(REQ_READ, 6'd63, 6'd63, 1'b0);
      issue_request(REQ_READ, 6'd0, 6'd63, 1'b1);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         csr_access(CSR_COLS, 1'b1, phase_cols[p]);
         csr_access(CSR_ROWS, 1'b1, phase_rows[p]);
         csr_access(CSR_COLS, 1'b0, '0);
         csr_access(CSR_ROWS, 1'b0, '0);
         area_cols = int'(phase_cols[p][DIM_W-1:0]);
         area_rows = int'(phase_rows[p][DIM_W-1:0]);
         area_cols = (area_cols < int'(DIM_MIN)) ? int'(DIM_MIN) :
                     (area_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : area_cols;
         area_rows = (area_rows < int'(DIM_MIN)) ? int'(DIM_MIN) :
                     (area_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : area_rows;
         for (int i = 0; i < 16; i++) begin
            pick = $urandom_range(0, 99);
            col = 6'($urandom_range(0, 63));
            row = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 4) != 0) begin
               col = 6'($urandom_range(0, area_cols - 1));
               row = 6'($urandom_range(0, area_rows - 1));
            end
            kind = (pick < 45) ? REQ_SET : (pick < 75) ? REQ_READ :
                   (pick < 95) ? REQ_STEP : REQ_CLEAR;
            issue_request(kind, col, row, $urandom_range(0, 2) != 0);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lts_pkg.sv
rtl/lts_ram.sv
rtl/lts_ctrl.sv
rtl/lts_datapath.sv
rtl/life_torus_generation_step.sv
tb/life_torus_generation_step_checker.sv
tb/life_torus_generation_step_test.sv
